>>> sv/bdcm_pkg.sv
// shared types and constants of the block-diagonal complex matrix-vector unit
package bdcm_pkg;

  localparam int DATA_W      = 32;
  localparam int ACC_W       = 48;
  localparam int PROD_SHIFT  = 30;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DEG_REG_W   = 4;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ENTRY = 1'b1;

  // one matrix entry with its coefficient, handed from front to back
  typedef struct packed {
    logic signed [DATA_W-1:0] coef_re;
    logic signed [DATA_W-1:0] coef_im;
    logic signed [DATA_W-1:0] ent_re;
    logic signed [DATA_W-1:0] ent_im;
    logic                     row_end;
    logic                     fin;
  } item_t;

endpackage

>>> sv/block_diagonal_complex_matvec_top.sv
// Block-diagonal complex matrix times coefficient vector, Q16.16 x Q2.30 with
// 48-bit accumulation. Items with tuser low load coefficients in order; items
// with tuser high stream matrix entries row by row, and every 2l+1 entries give
// one saturated row sum, the last row of the last block flagged by tlast. One
// item is taken per cycle when nothing stalls: the coefficient store has a
// single port used once per item, and the multiply-accumulate loop feeds the
// accumulator straight back to itself. A row sum goes from the edge that takes
// its last entry through the store read on that edge, then queue, product
// register, sum register and output register. The store has no reset; every
// coefficient read must have been loaded first.
module block_diagonal_complex_matvec_top #(
  parameter int MAX_DEGREE  = 15,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [bdcm_pkg::DEG_REG_W-1:0]      cfg_wdata,  // top_degree
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [2*bdcm_pkg::DATA_W-1:0]       s_tdata,    // value_re, value_im
  input  logic                                s_tuser,    // mode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*bdcm_pkg::DATA_W-1:0]       m_tdata,    // result_re, result_im
  output logic                                m_tuser,    // saturated
  output logic                                m_tlast
);
  import bdcm_pkg::*;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t push_item;
  item_t pop_item;

  bdcm_front #(
    .MAX_DEGREE  (MAX_DEGREE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  bdcm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  bdcm_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sv/bdcm_front.sv
// front end: takes items, keeps the coefficient store and walks the block counters
module bdcm_front #(
  parameter int MAX_DEGREE  = 15,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [bdcm_pkg::DEG_REG_W-1:0]      cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [2*bdcm_pkg::DATA_W-1:0]       s_tdata,
  input  logic                                s_tuser,
  input  logic                                q_full,
  output logic                                q_push,
  output bdcm_pkg::item_t                     q_item
);
  import bdcm_pkg::*;

  localparam int DEG_W = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int CW    = $clog2(2 * MAX_DEGREE + 2);
  localparam int SHIFT = DATA_W - VALUE_WIDTH;

  logic [DEG_REG_W-1:0] top_degree;
  logic [ADDR_W-1:0]    load_ptr;
  logic [CW-1:0]        col;
  logic [CW-1:0]        row;
  logic [DEG_W-1:0]     deg;
  logic [ADDR_W-1:0]    base;

  logic [2*DATA_W-1:0]  store [STORE_DEPTH];
  logic [2*DATA_W-1:0]  rd_data;

  logic                     s1_valid;
  logic signed [DATA_W-1:0] s1_ent_re;
  logic signed [DATA_W-1:0] s1_ent_im;
  logic                     s1_row_end;
  logic                     s1_fin;

  logic                     accept;
  logic                     is_load;
  logic                     is_entry;
  logic signed [DATA_W-1:0] val_re;
  logic signed [DATA_W-1:0] val_im;
  logic [CW-1:0]            size;
  logic                     col_last;
  logic                     row_last;
  logic [ADDR_W-1:0]        top_lim;
  logic                     deg_last;
  logic [ADDR_W-1:0]        rd_addr;

  // keep the low value bits, sign-extended to the full word
  function automatic logic signed [DATA_W-1:0] sext(input logic [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] t;
    t = x <<< SHIFT;
    return t >>> SHIFT;
  endfunction

  always_comb begin
    val_re   = sext(s_tdata[DATA_W-1:0]);
    val_im   = sext(s_tdata[2*DATA_W-1:DATA_W]);
    s_tready = !s1_valid || !q_full;
    accept   = s_tvalid && s_tready;
    is_load  = accept && (s_tuser == MODE_LOAD);
    is_entry = accept && (s_tuser == MODE_ENTRY);
    size     = CW'({deg, 1'b1});
    col_last = (col + CW'(1)) == size;
    row_last = (row + CW'(1)) == size;
    top_lim  = ({{(ADDR_W-DEG_REG_W){1'b0}}, top_degree} > ADDR_W'(MAX_DEGREE)) ?
               ADDR_W'(MAX_DEGREE) : {{(ADDR_W-DEG_REG_W){1'b0}}, top_degree};
    deg_last = ADDR_W'(deg) >= top_lim;
    rd_addr  = base + ADDR_W'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_degree <= '0;
    end else if (cfg_wen) begin
      top_degree <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr <= '0;
      col      <= '0;
      row      <= '0;
      deg      <= '0;
      base     <= '0;
    end else begin
      if (is_load) begin
        load_ptr <= load_ptr + ADDR_W'(1);
      end
      if (is_entry) begin
        if (!col_last) begin
          col <= col + CW'(1);
        end else begin
          col <= '0;
          if (!row_last) begin
            row <= row + CW'(1);
          end else begin
            row <= '0;
            if (deg_last) begin
              deg  <= '0;
              base <= '0;
            end else begin
              deg  <= deg + DEG_W'(1);
              base <= base + ADDR_W'(size);
            end
          end
        end
      end
    end
  end

  // coefficient store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (is_load) begin
      store[load_ptr] <= {val_im, val_re};
    end
    if (is_entry) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (is_entry) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_entry) begin
      s1_ent_re  <= val_re;
      s1_ent_im  <= val_im;
      s1_row_end <= col_last;
      s1_fin     <= col_last && row_last && deg_last;
    end
  end

  always_comb begin
    q_push          = s1_valid && !q_full;
    q_item.coef_re  = rd_data[DATA_W-1:0];
    q_item.coef_im  = rd_data[2*DATA_W-1:DATA_W];
    q_item.ent_re   = s1_ent_re;
    q_item.ent_im   = s1_ent_im;
    q_item.row_end  = s1_row_end;
    q_item.fin      = s1_fin;
  end

endmodule

>>> sv/bdcm_queue.sv
// short fifo between the front and back ends
module bdcm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bdcm_pkg::item_t push_item,
  input  logic            pop,
  output bdcm_pkg::item_t pop_item,
  output logic            full,
  output logic            empty
);
  import bdcm_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    full     = count == QCNT_W'(QUEUE_DEPTH);
    empty    = count == '0;
    pop_item = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count lost a transfer");

endmodule

>>> sv/bdcm_back.sv
// back end: complex multiply, row accumulation, saturation and output register
module bdcm_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  bdcm_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [2*bdcm_pkg::DATA_W-1:0] m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import bdcm_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic                       en;

  logic                       p1_valid;
  logic signed [2*DATA_W-1:0] p_rr;
  logic signed [2*DATA_W-1:0] p_ii;
  logic signed [2*DATA_W-1:0] p_ri;
  logic signed [2*DATA_W-1:0] p_ir;
  logic                       p1_row_end;
  logic                       p1_fin;

  logic signed [ACC_W-1:0]    acc_re;
  logic signed [ACC_W-1:0]    acc_im;
  logic signed [ACC_W-1:0]    sum_re_next;
  logic signed [ACC_W-1:0]    sum_im_next;

  logic                       p2_valid;
  logic signed [ACC_W-1:0]    sum_re;
  logic signed [ACC_W-1:0]    sum_im;
  logic                       p2_fin;

  logic signed [DATA_W-1:0]   sat_re;
  logic signed [DATA_W-1:0]   sat_im;
  logic                       clip_re;
  logic                       clip_im;

  // whole back end moves together unless a result waits at the output
  always_comb begin
    en    = !m_tvalid || m_tready;
    q_pop = en && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_rr       <= q_item.coef_re * q_item.ent_re;
      p_ii       <= q_item.coef_im * q_item.ent_im;
      p_ri       <= q_item.coef_re * q_item.ent_im;
      p_ir       <= q_item.coef_im * q_item.ent_re;
      p1_row_end <= q_item.row_end;
      p1_fin     <= q_item.fin;
    end
  end

  // products drop to q16.16 by a flooring shift before they are combined
  always_comb begin
    sum_re_next = acc_re + ACC_W'(p_rr >>> PROD_SHIFT) - ACC_W'(p_ii >>> PROD_SHIFT);
    sum_im_next = acc_im + ACC_W'(p_ri >>> PROD_SHIFT) + ACC_W'(p_ir >>> PROD_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re   <= '0;
      acc_im   <= '0;
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid && p1_row_end;
      if (p1_valid) begin
        if (p1_row_end) begin
          acc_re <= '0;
          acc_im <= '0;
        end else begin
          acc_re <= sum_re_next;
          acc_im <= sum_im_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && p1_valid && p1_row_end) begin
      sum_re <= sum_re_next;
      sum_im <= sum_im_next;
      p2_fin <= p1_fin;
    end
  end

  always_comb begin
    clip_re = 1'b0;
    clip_im = 1'b0;
    sat_re  = sum_re[DATA_W-1:0];
    sat_im  = sum_im[DATA_W-1:0];
    if (sum_re > SAT_HI) begin
      sat_re  = SAT_HI[DATA_W-1:0];
      clip_re = 1'b1;
    end else if (sum_re < SAT_LO) begin
      sat_re  = SAT_LO[DATA_W-1:0];
      clip_re = 1'b1;
    end
    if (sum_im > SAT_HI) begin
      sat_im  = SAT_HI[DATA_W-1:0];
      clip_im = 1'b1;
    end else if (sum_im < SAT_LO) begin
      sat_im  = SAT_LO[DATA_W-1:0];
      clip_im = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p2_valid) begin
      m_tdata <= {sat_im, sat_re};
      m_tuser <= clip_re || clip_im;
      m_tlast <= p2_fin;
    end
  end

endmodule

>>> dv/tb_block_diagonal_complex_matvec_top.sv
// self-checking testbench for the block-diagonal complex matrix-vector unit
module tb_block_diagonal_complex_matvec_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdcm_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int N_DIRECTED   = 21;
  localparam int RANDOM_ITEMS = 680;
  localparam int DRAIN_CYCLES = 12;
  localparam int STUCK_LIMIT  = 1000;

  localparam logic signed [47:0] SUM_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'shFFFF_8000_0000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
    logic        sat;
  } row_sum_t;

  typedef struct packed {
    logic        is_cfg;  // degree write, value in re[3:0]
    logic        mode;
    logic [31:0] re;
    logic [31:0] im;
    logic        typed;   // want holds the row sum to expect
    row_sum_t    want;
  } stim_row_t;

  localparam row_sum_t NO_SUM = '0;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_wen   = 1'b0;
  logic [DEG_REG_W-1:0]   cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [2*DATA_W-1:0]    s_tdata   = '0;   // value_re, value_im
  logic                   s_tuser   = 1'b0; // mode
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [2*DATA_W-1:0]    m_tdata;          // result_re, result_im
  logic                   m_tuser;          // saturated
  logic                   m_tlast;

  block_diagonal_complex_matvec_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // predictor state
  logic signed [31:0] coef_re_q [256];
  logic signed [31:0] coef_im_q [256];
  bit                 written [256];
  logic [7:0]         load_ptr_q = '0;
  logic signed [47:0] acc_re_q   = '0;
  logic signed [47:0] acc_im_q   = '0;
  int unsigned        col_q      = 0;
  int unsigned        row_q      = 0;
  int unsigned        deg_q      = 0;
  logic [7:0]         base_q     = '0;
  int unsigned        top_q      = 0;

  row_sum_t row_sums [$];

  int  errors       = 0;
  int  items_sent   = 0;
  int  sums_checked = 0;
  int  sat_seen     = 0;
  int  last_seen    = 0;
  int  burst_left   = 0;
  int  ready_hold   = 0;
  int  stuck_cycles = 0;
  bit  calm_phase   = 1'b0;
  bit  degrees_used [16];

  stim_row_t directed_rows [N_DIRECTED] = '{
    // 1.0 at index 0, then degree-0 products of one row each
    '{1'b0, MODE_LOAD,  32'h0001_0000, 32'h0000_0000, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h4000_0000, 32'h0000_0000, 1'b1,
      '{32'h0001_0000, 32'h0000_0000, 1'b1, 1'b0}},
    '{1'b0, MODE_ENTRY, 32'h0000_0000, 32'h4000_0000, 1'b1,
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0}},
    '{1'b0, MODE_ENTRY, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
      '{32'h0001_FFFF, 32'hFFFE_0000, 1'b1, 1'b0}},
    '{1'b0, MODE_ENTRY, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
      '{32'hFFFE_0000, 32'h0001_FFFF, 1'b1, 1'b0}},
    // shift rounds toward minus infinity
    '{1'b0, MODE_ENTRY, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0}},
    '{1'b0, MODE_LOAD,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_SUM},
    '{1'b0, MODE_LOAD,  32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{1'b0, MODE_LOAD,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, NO_SUM},
    '{1'b1, MODE_LOAD,  32'h0000_0001, 32'h0000_0000, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h4000_0000, 32'h0000_0000, 1'b1,
      '{32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0}},
    // degree-1 block over the extreme coefficients, saturating first row
    '{1'b0, MODE_ENTRY, 32'h8000_0000, 32'h8000_0000, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_SUM},
    // a load in the middle of a product
    '{1'b0, MODE_LOAD,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h0000_0000, 32'h4000_0000, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'h4000_0000, 32'h0000_0000, 1'b0, NO_SUM},
    '{1'b0, MODE_ENTRY, 32'hC000_0000, 32'hC000_0000, 1'b0, NO_SUM}
  };

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  // Q16.16 times Q2.30, shifted back to Q16.16
  function automatic logic signed [47:0] q30_product(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    logic signed [63:0] wide;
    wide = a * b;
    wide = wide >>> 30;
    return wide[47:0];
  endfunction

  // bit 32 flags a clip
  function automatic logic [32:0] clip32(input logic signed [47:0] a);
    if (a > SUM_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (a < SUM_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, a[31:0]};
  endfunction

  task automatic predict_row_sum(input logic mode, input logic [31:0] re,
                                 input logic [31:0] im, output bit gave,
                                 output row_sum_t r);
    logic signed [31:0] ar, ai, vr, vi;
    logic [32:0]        c_re, c_im;
    logic [7:0]         slot;
    int unsigned        size;
    gave = 1'b0;
    r    = NO_SUM;
    vr   = re;
    vi   = im;
    if (mode == MODE_LOAD) begin
      coef_re_q[load_ptr_q] = vr;
      coef_im_q[load_ptr_q] = vi;
      written[load_ptr_q]   = 1'b1;
      load_ptr_q++;
      return;
    end
    size = 2 * deg_q + 1;
    slot = base_q + col_q[7:0];
    ar   = coef_re_q[slot];
    ai   = coef_im_q[slot];
    acc_re_q += q30_product(ar, vr) - q30_product(ai, vi);
    acc_im_q += q30_product(ar, vi) + q30_product(ai, vr);
    col_q++;
    if (col_q < size) return;
    gave     = 1'b1;
    c_re     = clip32(acc_re_q);
    c_im     = clip32(acc_im_q);
    r.re     = c_re[31:0];
    r.im     = c_im[31:0];
    r.sat    = c_re[32] | c_im[32];
    acc_re_q = '0;
    acc_im_q = '0;
    col_q    = 0;
    row_q++;
    if (row_q >= size) begin
      row_q = 0;
      if (deg_q >= top_q) begin
        r.last = 1'b1;
        deg_q  = 0;
        base_q = '0;
      end else begin
        base_q = base_q + size[7:0];
        deg_q++;
      end
    end
  endtask

  // one transfer on the input side, bursts separated by random gaps
  task automatic send_item(input logic mode, input logic [31:0] re, input logic [31:0] im,
                           input bit typed, input row_sum_t want,
                           output bit gave, output bit fin);
    int       gap;
    row_sum_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = calm_phase ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {im, re};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    predict_row_sum(mode, re, im, gave, r);
    fin = r.last;
    if (gave) row_sums.push_back(typed ? want : r);
  endtask

  task automatic set_top_degree(input logic [3:0] v);
    s_tvalid <= 1'b0;
    while (row_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    top_q      = 32'(v);
    burst_left = 0;
    degrees_used[v] = 1'b1;
  endtask

  function automatic logic [31:0] pick_value(input bit entry);
    logic [31:0] corner [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0:       v = corner[$urandom_range(0, 3)];
      1, 2:    ;
      // below one half in magnitude for entries, a few units for coefficients
      default: v = entry ? {{2{v[29]}}, v[29:0]} : {{12{v[19]}}, v[19:0]};
    endcase
    return v;
  endfunction

  // loads in order until every coefficient up to need-1 holds a value
  task automatic fill_store(input int need);
    bit gave, fin;
    while (!written[need-1])
      send_item(MODE_LOAD, pick_value(1'b0), pick_value(1'b0), 1'b0, NO_SUM, gave, fin);
  endtask

  task automatic run_rows(input int rows, input bit to_end);
    int done;
    bit gave, fin, closed;
    done   = 0;
    closed = 1'b0;
    while (to_end ? !closed : (done < rows)) begin
      if ($urandom_range(0, 11) == 0)
        send_item(MODE_LOAD, pick_value(1'b0), pick_value(1'b0), 1'b0, NO_SUM, gave, fin);
      send_item(MODE_ENTRY, pick_value(1'b1), pick_value(1'b1), 1'b0, NO_SUM, gave, fin);
      if (gave) done++;
      if (fin) closed = 1'b1;
    end
  endtask

  // receiver: ready runs and stall runs of random length
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (m_tready && !calm_phase) begin
      m_tready   <= 1'b0;
      ready_hold <= $urandom_range(0, 5);
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    row_sum_t head;
    if (!rst && m_tvalid && m_tready) begin
      sums_checked++;
      if (m_tuser) sat_seen++;
      if (m_tlast) last_seen++;
      if (row_sums.size() == 0) begin
        report_mismatch($sformatf("row sum %h with none expected", m_tdata));
      end else begin
        head = row_sums.pop_front();
        if (m_tdata[31:0] !== head.re)
          report_mismatch($sformatf("result_re %h, expected %h", m_tdata[31:0], head.re));
        if (m_tdata[63:32] !== head.im)
          report_mismatch($sformatf("result_im %h, expected %h", m_tdata[63:32], head.im));
        if (m_tlast !== head.last)
          report_mismatch($sformatf("last %b, expected %b", m_tlast, head.last));
        if (m_tuser !== head.sat)
          report_mismatch($sformatf("saturated %b, expected %b", m_tuser, head.sat));
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("no transfer for %0d cycles, %0d row sums outstanding",
               STUCK_LIMIT, row_sums.size());
      $display("block_diagonal_complex_matvec_top: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned t, k;
    int          n_degrees;
    bit          gave, fin;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    degrees_used[0] = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        set_top_degree(directed_rows[i].re[3:0]);
      else
        send_item(directed_rows[i].mode, directed_rows[i].re, directed_rows[i].im,
                  directed_rows[i].typed, directed_rows[i].want, gave, fin);
    end

    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      calm_phase <= ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(4, 20))
            send_item(MODE_LOAD, pick_value(1'b0), pick_value(1'b0), 1'b0, NO_SUM, gave, fin);
        end
        1: begin
          // degree lowered part way into block k ends the product there
          t = $urandom_range(3, 6);
          k = $urandom_range(1, 2);
          set_top_degree(4'(t));
          fill_store((t + 1) * (t + 1));
          run_rows(k * k + $urandom_range(0, 2 * k), 1'b0);
          set_top_degree(4'($urandom_range(0, k)));
          run_rows(0, 1'b1);
        end
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2: t = 0;
            8:       t = 3;
            9:       t = 4;
            default: t = $urandom_range(1, 2);
          endcase
          set_top_degree(4'(t));
          fill_store((t + 1) * (t + 1));
          run_rows(0, 1'b1);
        end
      endcase
    end

    // highest degree written, then lowered once block 1 has ended
    calm_phase <= 1'b0;
    set_top_degree(4'd15);
    fill_store(9);
    run_rows(4, 1'b0);
    set_top_degree(4'd1);
    run_rows(0, 1'b1);

    s_tvalid <= 1'b0;
    while (row_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    n_degrees = 0;
    foreach (degrees_used[d]) n_degrees += int'(degrees_used[d]);
    $display("%0d input transfers, %0d row sums checked, %0d saturated, %0d closing a product",
             items_sent, sums_checked, sat_seen, last_seen);
    $display("%0d distinct top degrees used, %0d mismatches", n_degrees, errors);
    if (errors == 0) begin
      $display("block_diagonal_complex_matvec_top: match");
    end else begin
      $display("block_diagonal_complex_matvec_top: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bdcm_pkg.sv
sv/bdcm_front.sv
sv/bdcm_queue.sv
sv/bdcm_back.sv
sv/block_diagonal_complex_matvec_top.sv
dv/tb_block_diagonal_complex_matvec_top.sv
